// File: rtl/dpc_pkg.sv
// Shared types and constants of the detector packet checker.
// Used by dpc_cfg_regs, dpc_frame_track and detector_packet_checker.
`default_nettype none

package dpc_pkg;

	// Width of the byte position counter within one packet.
	localparam int unsigned POS_W = 17;
	localparam int unsigned CFG_IDX_W = 3;

	// Number of bytes in front of the payload: two sync, two id, two length.
	localparam logic [POS_W-1:0] HDR_BYTES = POS_W'(6);

	// Fixed header positions.
	localparam logic [POS_W-1:0] POS_SYNC_FIRST = POS_W'(0);
	localparam logic [POS_W-1:0] POS_SYNC_SECOND = POS_W'(1);
	localparam logic [POS_W-1:0] POS_PID_FIRST = POS_W'(2);
	localparam logic [POS_W-1:0] POS_PID_SECOND = POS_W'(3);
	localparam logic [POS_W-1:0] POS_LEN_HIGH = POS_W'(4);
	localparam logic [POS_W-1:0] POS_LEN_LOW = POS_W'(5);

	// First id byte that marks an acknowledge.
	localparam logic [7:0] PID_ACK_MARK = 8'hFF;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_PID_FIRST = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_PID_SECOND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH = 3'd4;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_ACK        = 3'd1,
		ST_WRONG_ID   = 3'd2,
		ST_SYNC_ERR   = 3'd3,
		ST_CKSUM_ERR  = 3'd4,
		ST_LENGTH_ERR = 3'd5
	} status_code_t;

	typedef struct packed {
		logic [7:0]  sync_first;
		logic [7:0]  sync_second;
		logic [7:0]  exp_pid_first;
		logic [7:0]  exp_pid_second;
		logic [15:0] payload_length;
	} cfg_t;

	typedef struct packed {
		logic         is_status;
		logic [7:0]   payload_byte;
		status_code_t status_code;
		logic [7:0]   got_pid_first;
		logic [7:0]   got_pid_second;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/dpc_cfg_regs.sv
// Configuration register file of the detector packet checker.
// Depends on dpc_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module dpc_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [dpc_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [15:0]                   wr_data,
	output dpc_pkg::cfg_t                      cfg
);
	import dpc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first     <= 8'd245;
			cfg_q.sync_second    <= 8'd250;
			cfg_q.exp_pid_first  <= 8'd0;
			cfg_q.exp_pid_second <= 8'd0;
			cfg_q.payload_length <= 16'd0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_SYNC_FIRST:     cfg_q.sync_first     <= wr_data[7:0];
				CFG_SYNC_SECOND:    cfg_q.sync_second    <= wr_data[7:0];
				CFG_EXP_PID_FIRST:  cfg_q.exp_pid_first  <= wr_data[7:0];
				CFG_EXP_PID_SECOND: cfg_q.exp_pid_second <= wr_data[7:0];
				CFG_PAYLOAD_LENGTH: cfg_q.payload_length <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/dpc_frame_track.sv
// Packet framing state and per-byte classification of the packet checker.
// Depends on dpc_pkg for positions, status codes and the result bundle.
`default_nettype none

module dpc_frame_track (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    rx_byte,
	input  wire dpc_pkg::cfg_t cfg,
	output logic               produce,
	output dpc_pkg::result_t   res
);
	import dpc_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [15:0]      sum_q;
	logic             sync_bad_q;
	logic [7:0]       pid_first_q;
	logic [7:0]       pid_second_q;
	logic [15:0]      length_q;

	logic [POS_W-1:0] cks_hi;
	logic [POS_W-1:0] last_pos;
	logic             at_end;
	logic             at_payload;
	logic [15:0]      sum_add;
	logic [15:0]      sum_next;
	logic [15:0]      final_sum;
	status_code_t     code;

	assign cks_hi     = {1'b0, cfg.payload_length} + HDR_BYTES;
	assign last_pos   = cks_hi + POS_W'(1);
	assign at_end     = (pos_q >= last_pos);
	assign at_payload = (pos_q >= HDR_BYTES) && (pos_q < cks_hi);

	// The high checksum byte carries weight 256; every other byte adds plainly.
	assign sum_add   = (pos_q == cks_hi) ? {rx_byte, 8'h00} : {8'h00, rx_byte};
	assign sum_next  = sum_q + sum_add;
	assign final_sum = sum_q + {8'h00, rx_byte};

	always_comb begin
		if (pid_first_q != cfg.exp_pid_first || pid_second_q != cfg.exp_pid_second) begin
			code = (pid_first_q == PID_ACK_MARK) ? ST_ACK : ST_WRONG_ID;
		end else if (sync_bad_q) begin
			code = ST_SYNC_ERR;
		end else if (final_sum != 16'd0) begin
			code = ST_CKSUM_ERR;
		end else if (length_q != cfg.payload_length) begin
			code = ST_LENGTH_ERR;
		end else begin
			code = ST_OK;
		end
	end

	always_comb begin
		produce            = at_end || at_payload;
		res.is_status      = at_end;
		res.payload_byte   = at_end ? 8'h00 : rx_byte;
		res.status_code    = at_end ? code : ST_OK;
		res.got_pid_first  = at_end ? pid_first_q : 8'h00;
		res.got_pid_second = at_end ? pid_second_q : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			sum_q        <= '0;
			sync_bad_q   <= 1'b0;
			pid_first_q  <= '0;
			pid_second_q <= '0;
			length_q     <= '0;
		end else if (step) begin
			if (at_end) begin
				pos_q        <= '0;
				sum_q        <= '0;
				sync_bad_q   <= 1'b0;
				pid_first_q  <= '0;
				pid_second_q <= '0;
				length_q     <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				sum_q <= sum_next;
				case (pos_q)
					POS_SYNC_FIRST:  sync_bad_q <= (rx_byte != cfg.sync_first);
					POS_SYNC_SECOND: sync_bad_q <= sync_bad_q | (rx_byte != cfg.sync_second);
					POS_PID_FIRST:   pid_first_q <= rx_byte;
					POS_PID_SECOND:  pid_second_q <= rx_byte;
					POS_LEN_HIGH:    length_q[15:8] <= rx_byte;
					POS_LEN_LOW:     length_q[7:0] <= rx_byte;
					default: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/detector_packet_checker.sv
// Top level of the detector packet checker: input register, framing logic, result register.
// Depends on dpc_pkg, dpc_cfg_regs and dpc_frame_track.
//
// Usage. Received bytes enter on the rx channel (rx_valid, rx_stall, rx_byte) in packet order:
// two sync bytes, two packet-id bytes, a big-endian length, the payload and a big-endian
// checksum. Each payload byte leaves on the result channel (res_valid, res_stall) as a
// transaction with is_status low. The low checksum byte closes the packet and is answered by a
// status transaction with is_status high, carrying status_code and
// the received id bytes; downstream discards the payload when the status is not ok.
// Header bytes and the high checksum byte produce no result transaction.
// The result passes through the input register and then the result register to the outputs;
// one byte is accepted per cycle while res_stall stays low, as the input register and the result
// register each hold one transaction and every byte needs only one compare and one 16-bit add.
// When the receiver raises res_stall the result register holds its transaction; the input
// register then fills and rx_stall rises, so nothing is lost or repeated.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready; it
// should be written only while no byte is in flight. Unknown indexes are ignored.
// An asynchronous reset (arst_n low) empties both registers, restarts the packet at its first
// sync byte and loads the configuration defaults.
`default_nettype none

module detector_packet_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Received byte channel.
	input  wire logic                          rx_valid,
	output logic                               rx_stall,
	input  wire logic [7:0]                    rx_byte,
	// Result channel.
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic                               is_status,
	output logic [7:0]                         payload_byte,
	output logic [2:0]                         status_code,
	output logic [7:0]                         got_pid_first,
	output logic [7:0]                         got_pid_second,
	// Configuration write channel.
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [dpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]                   cfg_data
);
	import dpc_pkg::*;

	cfg_t    cfg;
	result_t res_comb;
	result_t res_q;
	logic    produce;
	logic    byte_valid_s1;
	logic    [7:0] byte_s1;
	logic    res_valid_q;
	logic    advance;
	logic    rx_accept;

	assign cfg_ready = 1'b1;

	dpc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The byte in the input register moves on whenever the result register is empty or is
	// being emptied in this cycle.
	assign advance   = byte_valid_s1 && (!res_valid_q || !res_stall);
	assign rx_stall  = byte_valid_s1 && !advance;
	assign rx_accept = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (rx_accept) begin
			byte_valid_s1 <= 1'b1;
		end else if (advance) begin
			byte_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_accept) begin
			byte_s1 <= rx_byte;
		end
	end

	dpc_frame_track u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.produce (produce),
		.res     (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= produce;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			res_q <= res_comb;
		end
	end

	assign res_valid      = res_valid_q;
	assign is_status      = res_q.is_status;
	assign payload_byte   = res_q.payload_byte;
	assign status_code    = res_q.status_code;
	assign got_pid_first  = res_q.got_pid_first;
	assign got_pid_second = res_q.got_pid_second;

	// A status transaction never carries a payload byte.
	a_status_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.is_status |-> res_q.payload_byte == 8'h00)
		else $error("status transaction carries a payload byte");

	// A payload transaction reports ok and no id bytes.
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.is_status |->
		res_q.status_code == ST_OK && res_q.got_pid_first == 8'h00 &&
		res_q.got_pid_second == 8'h00)
		else $error("payload transaction carries status fields");

	// The input register only stalls behind a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> res_valid_q && res_stall)
		else $error("input stalled without a held result");

	// A byte held in the input register is processed once the result side frees up.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid_s1 && !res_valid_q && !rx_valid |=> !byte_valid_s1)
		else $error("input register failed to drain");

endmodule

`default_nettype wire

// File: tb/detector_packet_checker_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of detector_packet_checker: framed byte packets in, payload and status
// transactions predicted and compared field by field. Depends on dpc_pkg and the RTL top only.

module detector_packet_checker_tb;
	import dpc_pkg::*;

	localparam int unsigned CLK_PERIOD = 20;
	localparam int unsigned RESET_CYCLES = 6;
	// Bytes still pass through the block's input and result registers; leave a wide margin.
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned SEGMENTS = 8;
	localparam int unsigned SEGMENT_BYTES = 200;
	localparam int unsigned DIRECTED_COUNT = 24;
	localparam int unsigned LONG_HEAD_BYTES = 40;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = '1;
	localparam logic [15:0] MAX_LENGTH = 16'hFFFF;

	typedef enum int {
		PK_OK, PK_ACK, PK_WRONG_ID, PK_SYNC, PK_CKSUM, PK_LENGTH, PK_NOISE
	} pkt_kind_t;

	// One row of the directed table. Where typed is set, the row ends a packet and the status
	// written in the row is what the block must answer; other rows go through the predictor.
	typedef struct packed {
		logic [7:0]   rx;
		logic         typed;
		status_code_t code;
		logic [7:0]   pid_first;
		logic [7:0]   pid_second;
	} directed_row_t;

	// Three packets under the reset configuration (sync F5 FA, id 00 00, no payload):
	// a clean packet, an acknowledge carrying all-ones bytes, and a packet whose id, sync,
	// checksum and length are all wrong, where the id check must win.
	localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{8'hF5, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'hFA, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'h00, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'h00, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'h00, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'h00, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'hFE, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'h11, 1'b1, ST_OK,       8'h00, 8'h00},
		'{8'hF5, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'hFA, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'hFF, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'h5A, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'h00, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'h00, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'h00, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'hFF, 1'b1, ST_ACK,      8'hFF, 8'h5A},
		'{8'h00, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'hFF, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'h12, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'h34, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'hFF, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'hFF, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'h80, 1'b0, ST_OK,       8'h00, 8'h00},
		'{8'h7F, 1'b1, ST_WRONG_ID, 8'h12, 8'h34}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 rx_valid = 1'b0;
	logic                 rx_stall;
	logic [7:0]           rx_byte = 8'h00;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic                 is_status;
	logic [7:0]           payload_byte;
	logic [2:0]           status_code;
	logic [7:0]           got_pid_first;
	logic [7:0]           got_pid_second;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = 16'h0000;

	// Own copy of the configuration and of the framing state, updated at every accepted
	// transaction on the byte and configuration channels.
	cfg_t             model_cfg;
	logic [POS_W-1:0] model_pos;
	logic [15:0]      model_csum;
	logic             model_sync_bad;
	logic [7:0]       model_pid_first;
	logic [7:0]       model_pid_second;
	logic [15:0]      model_len_field;

	// Results still owed by the block, oldest first.
	result_t     pending_results[$];
	result_t     seen_result;
	result_t     want_result;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;
	bit          failed = 1'b0;

	detector_packet_checker u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_valid       (rx_valid),
		.rx_stall       (rx_stall),
		.rx_byte        (rx_byte),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.is_status      (is_status),
		.payload_byte   (payload_byte),
		.status_code    (status_code),
		.got_pid_first  (got_pid_first),
		.got_pid_second (got_pid_second),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic void restart_packet();
		model_pos = '0;
		model_csum = 16'h0000;
		model_sync_bad = 1'b0;
		model_pid_first = 8'h00;
		model_pid_second = 8'h00;
		model_len_field = 16'h0000;
	endfunction

	// Advances the framing state by one received byte. Returns 1 with the result filled in when
	// the byte is passed on as payload or closes the packet with a status.
	function automatic bit check_packet_byte(input logic [7:0] b, output result_t r);
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] cks_hi;
		status_code_t     code;
		r = '0;
		pos = model_pos;
		cks_hi = POS_W'(model_cfg.payload_length) + HDR_BYTES;
		// The byte after the high checksum byte, or any byte once a shortened length has left
		// the position behind, closes the packet.
		if (pos > cks_hi) begin
			model_csum += 16'(b);
			if (model_pid_first != model_cfg.exp_pid_first ||
					model_pid_second != model_cfg.exp_pid_second)
				code = (model_pid_first == PID_ACK_MARK) ? ST_ACK : ST_WRONG_ID;
			else if (model_sync_bad)
				code = ST_SYNC_ERR;
			else if (model_csum != 16'h0000)
				code = ST_CKSUM_ERR;
			else if (model_len_field != model_cfg.payload_length)
				code = ST_LENGTH_ERR;
			else
				code = ST_OK;
			r.is_status = 1'b1;
			r.status_code = code;
			r.got_pid_first = model_pid_first;
			r.got_pid_second = model_pid_second;
			restart_packet();
			return 1'b1;
		end
		// The checksum is big-endian, so its first byte weighs 256.
		model_csum += (pos == cks_hi) ? {b, 8'h00} : 16'(b);
		model_pos = pos + 1'b1;
		case (pos)
			POS_SYNC_FIRST: model_sync_bad = (b != model_cfg.sync_first);
			POS_SYNC_SECOND: begin
				if (b != model_cfg.sync_second)
					model_sync_bad = 1'b1;
			end
			POS_PID_FIRST: model_pid_first = b;
			POS_PID_SECOND: model_pid_second = b;
			POS_LEN_HIGH: model_len_field[15:8] = b;
			POS_LEN_LOW: model_len_field[7:0] = b;
			default: begin
				if (pos < cks_hi) begin
					r.payload_byte = b;
					return 1'b1;
				end
			end
		endcase
		return 1'b0;
	endfunction

	// Offers one byte, idling first at the chosen rate, and holds it until the block takes it.
	// A typed expectation replaces the predicted one for directed rows that carry it.
	task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
			input result_t typed_r = '0);
		result_t predicted;
		bit      produced;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			rx_valid <= 1'b0;
			@(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (rx_stall);
		produced = check_packet_byte(b, predicted);
		if (typed)
			pending_results.push_back(typed_r);
		else if (produced)
			pending_results.push_back(predicted);
		items_sent++;
	endtask

	// Fills out whatever packet is open with random bytes so that the next one starts framed.
	task automatic realign();
		while (model_pos != '0)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	// Builds one packet for the current configuration with the flaw that the kind asks for,
	// then sends it whole or only a random leading part of it; the noise kind sends random bytes.
	task automatic send_packet(input pkt_kind_t kind, input bit cut_short);
		logic [7:0]  frame[$];
		logic [7:0]  s1;
		logic [7:0]  s2;
		logic [7:0]  p1;
		logic [7:0]  p2;
		logic [15:0] len_field;
		logic [15:0] csum;
		logic [15:0] cks;
		int unsigned keep;
		realign();
		if (kind == PK_NOISE) begin
			repeat ($urandom_range(1, 12))
				send_byte(8'($urandom_range(0, 255)));
			return;
		end
		s1 = model_cfg.sync_first;
		s2 = model_cfg.sync_second;
		p1 = model_cfg.exp_pid_first;
		p2 = model_cfg.exp_pid_second;
		len_field = model_cfg.payload_length;
		case (kind)
			PK_ACK: begin
				p1 = PID_ACK_MARK;
				if (model_cfg.exp_pid_first == PID_ACK_MARK)
					p2 = model_cfg.exp_pid_second ^ 8'($urandom_range(1, 255));
				else
					p2 = 8'($urandom_range(0, 255));
			end
			PK_WRONG_ID: begin
				p1 = 8'($urandom_range(0, 254));
				if (p1 == model_cfg.exp_pid_first)
					p2 = model_cfg.exp_pid_second ^ 8'($urandom_range(1, 255));
				else
					p2 = 8'($urandom_range(0, 255));
			end
			PK_SYNC: begin
				case ($urandom_range(0, 2))
					0: s1 ^= 8'($urandom_range(1, 255));
					1: s2 ^= 8'($urandom_range(1, 255));
					default: begin
						s1 ^= 8'($urandom_range(1, 255));
						s2 ^= 8'($urandom_range(1, 255));
					end
				endcase
			end
			PK_LENGTH: len_field ^= 16'($urandom_range(1, 65535));
			default: ;
		endcase
		frame = {s1, s2, p1, p2, len_field[15:8], len_field[7:0]};
		repeat (model_cfg.payload_length)
			frame.push_back(8'($urandom_range(0, 255)));
		csum = 16'h0000;
		foreach (frame[i])
			csum += 16'(frame[i]);
		cks = 16'h0000 - csum;
		if (kind == PK_CKSUM)
			cks += 16'($urandom_range(1, 65535));
		frame.push_back(cks[15:8]);
		frame.push_back(cks[7:0]);
		keep = cut_short ? $urandom_range(1, frame.size() - 1) : frame.size();
		for (int unsigned n = 0; n < keep; n++)
			send_byte(frame[n]);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SYNC_FIRST: model_cfg.sync_first = data[7:0];
			CFG_SYNC_SECOND: model_cfg.sync_second = data[7:0];
			CFG_EXP_PID_FIRST: model_cfg.exp_pid_first = data[7:0];
			CFG_EXP_PID_SECOND: model_cfg.exp_pid_second = data[7:0];
			CFG_PAYLOAD_LENGTH: model_cfg.payload_length = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drops valid, lets every owed result arrive, then allows for a header or checksum byte
	// still in flight, which produces no result and so cannot be waited for directly.
	task automatic wait_idle();
		@(negedge clk);
		rx_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The receiver stalls at random, decided away from the sampling edge.
	always @(negedge clk)
		res_stall <= ($urandom_range(0, 99) < recv_stall_pct);

	// Every result transaction is matched against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			seen_result = {is_status, payload_byte, status_code, got_pid_first, got_pid_second};
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing expected: is_status %0d payload_byte %0h",
					seen_result.is_status, seen_result.payload_byte);
				failed = 1'b1;
			end else begin
				want_result = pending_results.pop_front();
				if (seen_result.is_status !== want_result.is_status) begin
					$error("is_status: expected %0d, got %0d",
						want_result.is_status, seen_result.is_status);
					failed = 1'b1;
				end
				if (seen_result.payload_byte !== want_result.payload_byte) begin
					$error("payload_byte: expected %0h, got %0h",
						want_result.payload_byte, seen_result.payload_byte);
					failed = 1'b1;
				end
				if (seen_result.status_code !== want_result.status_code) begin
					$error("status_code: expected %0d, got %0d",
						want_result.status_code, seen_result.status_code);
					failed = 1'b1;
				end
				if (seen_result.got_pid_first !== want_result.got_pid_first) begin
					$error("got_pid_first: expected %0h, got %0h",
						want_result.got_pid_first, seen_result.got_pid_first);
					failed = 1'b1;
				end
				if (seen_result.got_pid_second !== want_result.got_pid_second) begin
					$error("got_pid_second: expected %0h, got %0h",
						want_result.got_pid_second, seen_result.got_pid_second);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog: a stuck handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		result_t     row_result;
		logic [7:0]  cfg_bytes [4];
		logic [15:0] new_length;
		int unsigned pick;
		pkt_kind_t   kind;
		model_cfg = '{sync_first: 8'd245, sync_second: 8'd250, exp_pid_first: 8'd0,
			exp_pid_second: 8'd0, payload_length: 16'd0};
		restart_packet();
		// First phase: the sender idles now and then, the receiver stalls more often than not.
		send_idle_pct = 15;
		recv_stall_pct = 58;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		for (int unsigned i = 0; i < DIRECTED_COUNT; i++) begin
			row_result = '{is_status: 1'b1, payload_byte: 8'h00,
				status_code: DIRECTED_ROWS[i].code,
				got_pid_first: DIRECTED_ROWS[i].pid_first,
				got_pid_second: DIRECTED_ROWS[i].pid_second};
			send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].typed, row_result);
		end
		wait_idle();

		for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
			// Then the other way round, and finally back-to-back traffic with no idling.
			if (seg == 3) begin
				send_idle_pct = 58;
				recv_stall_pct = 15;
			end else if (seg == 6) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			// Segment 1 takes every register to zero and segment 2 the byte-wide ones to all ones; the
			// rest draw at random, mostly short payloads and now and then a longer one.
			for (int unsigned i = 0; i < 4; i++)
				cfg_bytes[i] = (seg == 1) ? 8'h00 : (seg == 2) ? 8'hFF :
					8'($urandom_range(0, 255));
			if (seg == 1)
				new_length = 16'd0;
			else if ($urandom_range(0, 3) == 0)
				new_length = 16'($urandom_range(25, 300));
			else
				new_length = 16'($urandom_range(0, 24));
			// The upper data bits of the byte-wide registers are junk that must be dropped.
			for (int unsigned i = 0; i < 4; i++)
				write_reg(CFG_IDX_W'(CFG_SYNC_FIRST + i), {8'($urandom_range(0, 255)), cfg_bytes[i]});
			write_reg(CFG_PAYLOAD_LENGTH, new_length);
			write_reg(CFG_IDX_W'($urandom_range(CFG_PAYLOAD_LENGTH + 1, CFG_IDX_TOP)),
				16'($urandom_range(0, 65535)));

			items_sent = 0;
			while (items_sent < SEGMENT_BYTES) begin
				pick = $urandom_range(0, 99);
				kind = (pick < 40) ? PK_OK : (pick < 48) ? PK_ACK : (pick < 56) ? PK_WRONG_ID :
					(pick < 66) ? PK_SYNC : (pick < 78) ? PK_CKSUM : (pick < 90) ? PK_LENGTH :
					PK_NOISE;
				send_packet(kind, $urandom_range(0, 99) < 6);
			end
			// Leaving a packet open lets the next configuration change land mid-packet.
			if (seg != SEGMENTS - 1 && $urandom_range(0, 1) == 1)
				send_packet(PK_OK, 1'b1);
			wait_idle();
		end

		// The longest payload the length register allows: the opening bytes of such a packet,
		// then a zero length closes it with the next byte.
		realign();
		wait_idle();
		write_reg(CFG_PAYLOAD_LENGTH, MAX_LENGTH);
		repeat (LONG_HEAD_BYTES)
			send_byte(8'($urandom_range(0, 255)));
		wait_idle();
		write_reg(CFG_PAYLOAD_LENGTH, 16'd0);
		send_byte(8'($urandom_range(0, 255)));
		wait_idle();

		if (!failed)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: detector_packet_checker.f
rtl/dpc_pkg.sv
rtl/dpc_cfg_regs.sv
rtl/dpc_frame_track.sv
rtl/detector_packet_checker.sv
tb/detector_packet_checker_tb.sv
